// File: rtl/core/wildcard_glob_matcher_top_assert.svh
// Assertion macros used by the glob matcher RTL
`ifndef WILDCARD_GLOB_MATCHER_TOP_ASSERT_SVH
`define WILDCARD_GLOB_MATCHER_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define WGM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define WGM_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/wgm_pkg.sv
// Package: types and constants of the glob matcher
`timescale 1ns / 1ps
`default_nettype none
package wgm_pkg;
	localparam int CHAR_W          = 8;
	localparam int LEN_W           = 6;
	localparam int PATTERN_MAX_DEF = 32;

	localparam logic [CHAR_W-1:0] CH_STAR     = 8'd42;
	localparam logic [CHAR_W-1:0] CH_QUESTION = 8'd63;

	// broadcast from the top level to every cell
	typedef struct packed {
		logic              pat;        // pattern word accepted
		logic              pat_start;  // that word opens a new pattern
		logic              pat_we;     // the word is stored (not dropped)
		logic [LEN_W-1:0]  wpos;       // store position of the word
		logic              txt;        // text word accepted
		logic              last;       // word ends its string
		logic              text_open;  // a text string is in progress
		logic [CHAR_W-1:0] ch;         // character of the word
	} cell_ctl_t;

	typedef struct packed {
		logic matched;
		logic pattern_overflow;
	} result_t;
endpackage
`default_nettype wire

// File: rtl/core/wgm_if.sv
// Channel interfaces: input words and result words
`timescale 1ns / 1ps
`default_nettype none
interface wgm_in_if;
	import wgm_pkg::*;
	logic              valid;
	logic              ready;
	logic              req_type;
	logic [CHAR_W-1:0] char_code;
	logic              is_last;

	modport source(output valid, req_type, char_code, is_last, input ready);
	modport sink(input valid, req_type, char_code, is_last, output ready);
endinterface

interface wgm_out_if;
	logic valid;
	logic ready;
	logic matched;
	logic pattern_overflow;

	modport source(output valid, matched, pattern_overflow, input ready);
	modport sink(input valid, matched, pattern_overflow, output ready);
endinterface
`default_nettype wire

// File: rtl/core/wgm_cell.sv
// One pattern position: stored character, prefix bit and star-tail flag
`timescale 1ns / 1ps
`default_nettype none
module wgm_cell #(
	parameter int IDX = 0
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire wgm_pkg::cell_ctl_t ctl,
	input  wire logic              clo_in,
	input  wire logic              adv_in,
	output logic                   clo_out,
	output logic                   adv_out,
	output logic                   hit
);
	import wgm_pkg::*;

	localparam logic SEED = (IDX == 0) ? 1'b1 : 1'b0;
	localparam logic [LEN_W-1:0] POS = LEN_W'(IDX);

	logic [CHAR_W-1:0] char_q;
	logic              valid_q;
	logic              tail_q;
	logic              raw_q;

	logic here;
	logic is_star;
	logic cur;
	logic next_raw;

	always_comb begin
		here     = ctl.pat_we && (ctl.wpos == POS);
		is_star  = (char_q == CH_STAR);
		// closed prefix bit: seed or stored raw bit, plus closure from the left
		cur      = (ctl.text_open ? raw_q : SEED) | clo_in;
		clo_out  = cur & valid_q & is_star;
		adv_out  = cur & valid_q & ~is_star &
			((char_q == CH_QUESTION) || (char_q == ctl.ch));
		next_raw = clo_out | adv_in;
		// tail flag: everything from here to the pattern end is a star
		hit      = next_raw & tail_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tail_q  <= 1'b1;
			raw_q   <= 1'b0;
		end else begin
			if (ctl.pat) begin
				valid_q <= here | (valid_q & ~ctl.pat_start);
				if (ctl.pat_we && (POS <= ctl.wpos) && (ctl.ch != CH_STAR))
					tail_q <= 1'b0;
				else
					tail_q <= ctl.pat_start | tail_q;
			end
			if (ctl.pat_start)
				raw_q <= 1'b0;
			else if (ctl.txt)
				raw_q <= ctl.last ? 1'b0 : next_raw;
		end
	end

	always_ff @(posedge clk) begin
		if (here)
			char_q <= ctl.ch;
	end
endmodule
`default_nettype wire

// File: rtl/core/wgm_out_queue.sv
// Two-entry result queue between the cell row and the result channel
`timescale 1ns / 1ps
`default_nettype none
module wgm_out_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire wgm_pkg::result_t push_data,
	output logic                  full,
	wgm_out_if.source             result
);
	import wgm_pkg::*;

	logic [1:0] cnt_q;
	result_t    ent0_q;
	result_t    ent1_q;
	logic       pop;
	logic [1:0] wr_idx;

	always_comb begin
		pop     = result.valid & result.ready;
		wr_idx  = cnt_q - {1'b0, pop};
		full    = (cnt_q == 2'd2);
		result.valid            = (cnt_q != 2'd0);
		result.matched          = ent0_q.matched;
		result.pattern_overflow = ent0_q.pattern_overflow;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= 2'd0;
		else
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
	end

	always_ff @(posedge clk) begin
		// on a pop from a full queue shift the head forward, then drop the new word in the first free slot
		if (pop && full)
			ent0_q <= ent1_q;
		if (push) begin
			if (wr_idx == 2'd0)
				ent0_q <= push_data;
			else
				ent1_q <= push_data;
		end
	end
endmodule
`default_nettype wire

// File: rtl/core/wildcard_glob_matcher_top.sv
// Glob matcher top level: pattern store as a row of cells, result queue
// The result is queued when the last text word is accepted; the queue presents results in order.
// Throughput: one word per cycle, pattern or text; ready drops only with two results queued.
// Cycle time is set by the star-closure ripple through the row of PATTERN_MAX cells.
// Reset clears pattern length, prefix bits, the queue and all flags but the tail flags, which it sets;
// stored characters are not cleared and are never read before they are written.
`timescale 1ns / 1ps
`default_nettype none
`include "wildcard_glob_matcher_top_assert.svh"
module wildcard_glob_matcher_top #(
	parameter int PATTERN_MAX = wgm_pkg::PATTERN_MAX_DEF
) (
	input wire logic  clk,
	input wire logic  arst_n,
	wgm_in_if.sink    item,
	wgm_out_if.source result
);
	import wgm_pkg::*;

	localparam int LEN_CW = $clog2(PATTERN_MAX + 1);
	localparam logic [LEN_CW-1:0] LEN_MAX = LEN_CW'(PATTERN_MAX);

	logic [LEN_CW-1:0] len_q;
	logic              pattern_open_q;
	logic              text_open_q;
	logic              overflow_q;

	logic              full;
	logic              accept;
	logic              pat;
	logic              txt;
	logic              pat_start;
	logic              pat_we;
	logic [LEN_CW-1:0] len_eff;
	logic              push;
	result_t           push_data;
	cell_ctl_t         ctl;

	logic [PATTERN_MAX:0]   clo;
	logic [PATTERN_MAX:0]   adv;
	logic [PATTERN_MAX-1:0] hit;

	always_comb begin
		item.ready = ~full;
		accept     = item.valid & ~full;
		pat        = accept & ~item.req_type;
		txt        = accept & item.req_type;
		pat_start  = pat & ~pattern_open_q;
		len_eff    = pat_start ? '0 : len_q;
		pat_we     = pat && (len_eff < LEN_MAX);

		ctl.pat       = pat;
		ctl.pat_start = pat_start;
		ctl.pat_we    = pat_we;
		ctl.wpos      = LEN_W'(len_eff);
		ctl.txt       = txt;
		ctl.last      = item.is_last;
		ctl.text_open = text_open_q;
		ctl.ch        = item.char_code;

		push                       = txt & item.is_last;
		push_data.matched          = (|hit) | adv[PATTERN_MAX];
		push_data.pattern_overflow = overflow_q;
	end

	// nothing enters the left end of the row
	assign clo[0] = 1'b0;
	assign adv[0] = 1'b0;

	for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
		wgm_cell #(
			.IDX(i)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.clo_in (clo[i]),
			.adv_in (adv[i]),
			.clo_out(clo[i+1]),
			.adv_out(adv[i+1]),
			.hit    (hit[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q          <= '0;
			pattern_open_q <= 1'b0;
			text_open_q    <= 1'b0;
			overflow_q     <= 1'b0;
		end else begin
			if (pat) begin
				len_q          <= pat_we ? len_eff + 1'b1 : len_eff;
				overflow_q     <= (overflow_q & ~pat_start) | ~pat_we;
				pattern_open_q <= ~item.is_last;
				if (pat_start)
					text_open_q <= 1'b0;
			end else if (txt) begin
				pattern_open_q <= 1'b0;
				text_open_q    <= ~item.is_last;
			end
		end
	end

	wgm_out_queue u_out_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (full),
		.result   (result)
	);

	`WGM_ASSERT_NXT(a_start_len, pat_start, len_q == 1, "new pattern must hold one char")
	`WGM_ASSERT_NOW(a_ovf_full, overflow_q, len_q == LEN_MAX, "overflow with room left")
	`WGM_ASSERT_NOW(a_len_range, 1'b1, len_q <= LEN_MAX, "pattern length out of range")
	`WGM_ASSERT_NXT(a_push_out, push, result.valid, "queued result not presented")
	`WGM_ASSERT_NXT(a_text_open, txt && !item.is_last, text_open_q, "text string not held open")
endmodule
`default_nettype wire
